// ----- design/nmea_sentence_checker_defines.svh -----
// ---------------------------------------------------------------------------
// NMEA sentence checker assertion macros
// Shared concurrent assertion forms, clocked on aclk and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef NMEA_SENTENCE_CHECKER_DEFINES_SVH
`define NMEA_SENTENCE_CHECKER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define NSC_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("nmea_sentence_checker: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define NSC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("nmea_sentence_checker: next-cycle check failed");

`endif

// ----- design/nmea_sc_pkg.sv -----
// ---------------------------------------------------------------------------
// NMEA sentence checker package
// Character codes, result record and decode helpers for the checker.
// ---------------------------------------------------------------------------
package nmea_sc_pkg;

    localparam int unsigned BUFFER_BYTES_DEFAULT = 128;
    localparam int unsigned PREFIX_LEN           = 6;

    localparam logic [7:0] CHAR_DOLLAR = 8'h24;
    localparam logic [7:0] CHAR_STAR   = 8'h2A;
    localparam logic [7:0] CHAR_LF     = 8'h0A;
    localparam logic [7:0] CHAR_CR     = 8'h0D;
    localparam logic [7:0] CHAR_NUL    = 8'h00;

    localparam logic [1:0] KIND_OTHER = 2'd0;
    localparam logic [1:0] KIND_GGA   = 2'd1;
    localparam logic [1:0] KIND_RMC   = 2'd2;

    // Prefix match bits: GPGGA, GNGGA, GPRMC, GNRMC from bit 0 upwards.
    localparam logic [3:0] PREFIX_ALL  = 4'hF;
    localparam logic [3:0] PREFIX_GGA  = 4'h3;
    localparam logic [3:0] PREFIX_RMC  = 4'hC;

    typedef struct packed {
        logic        sentence_done;
        logic        checksum_ok;
        logic [1:0]  sentence_kind;
        logic [31:0] crc_error_total;
        logic [31:0] valid_total;
        logic        fix_valid;
    } nmea_result_t;

    typedef struct packed {
        logic       valid;
        logic [3:0] value;
    } hex_digit_t;

    // Expected character at prefix position idx (after '$') for each of the four
    // known sentences, packed with GPGGA in the low byte.
    function automatic logic [31:0] prefix_column(input logic [2:0] idx);
        logic [31:0] col;
        unique case (idx)
            3'd0:    col = {8'h47, 8'h47, 8'h47, 8'h47};
            3'd1:    col = {8'h4E, 8'h50, 8'h4E, 8'h50};
            3'd2:    col = {8'h52, 8'h52, 8'h47, 8'h47};
            3'd3:    col = {8'h4D, 8'h4D, 8'h47, 8'h47};
            3'd4:    col = {8'h43, 8'h43, 8'h41, 8'h41};
            default: col = 32'h0;
        endcase
        return col;
    endfunction

    function automatic hex_digit_t hex_decode(input logic [7:0] b);
        hex_digit_t d;
        d.valid = 1'b1;
        if (b >= 8'h30 && b <= 8'h39) begin
            d.value = 4'(b - 8'h30);
        end else if (b >= 8'h41 && b <= 8'h46) begin
            d.value = 4'(b - 8'h37);
        end else if (b >= 8'h61 && b <= 8'h66) begin
            d.value = 4'(b - 8'h57);
        end else begin
            d.valid = 1'b0;
            d.value = 4'h0;
        end
        return d;
    endfunction

endpackage

// ----- design/nmea_sentence_checker.sv -----
// ---------------------------------------------------------------------------
// NMEA 0183 sentence checker
// Byte-serial XOR checksum check, sentence classification and statistics.
// ---------------------------------------------------------------------------
// Usage: received characters enter on the s_ channel (s_rx_byte, one per
// request). Every accepted byte yields exactly one request on the m_ channel.
// m_sentence_done marks the byte (CR or LF) that closed a sentence; with it,
// m_checksum_ok and m_sentence_kind give the verdict. The running totals and
// the fix flag are reported on every request, as they stand after that byte.
// Each result is registered, in the result register or the skid register.
// Throughput: one byte per cycle while s_ready is high; sentence state lives
// in a handful of small registers, updated by a single level of logic per byte.
// Stalls: a two-deep output stage (result register plus skid register) lets
// one byte be accepted while m_ready is low; s_ready drops once the skid
// register holds a result and rises again when the receiver takes one.
// Reset: aresetn (synchronous, active low) closes any open sentence, clears
// the counters and the fix flag and empties the output stage.
// ---------------------------------------------------------------------------
`include "nmea_sentence_checker_defines.svh"

module nmea_sentence_checker
    import nmea_sc_pkg::*;
#(
    parameter int unsigned BUFFER_BYTES = BUFFER_BYTES_DEFAULT
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_rx_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_sentence_done,
    output logic        m_checksum_ok,
    output logic [1:0]  m_sentence_kind,
    output logic [31:0] m_crc_error_total,
    output logic [31:0] m_valid_total,
    output logic        m_fix_valid
);

    localparam int unsigned CountW = $clog2(BUFFER_BYTES);
    localparam logic [CountW-1:0] CountLimit = CountW'(BUFFER_BYTES - 1);
    localparam logic [CountW-1:0] PrefixEnd  = CountW'(PREFIX_LEN);

    logic [CountW-1:0] count_reg, count_next;
    logic [7:0]        xor_reg, xor_next;
    logic              star_reg, star_next;
    logic              hex_active_reg, hex_active_next;
    logic [7:0]        hex_value_reg, hex_value_next;
    logic              nul_reg, nul_next;
    logic [3:0]        prefix_reg, prefix_next;
    logic [31:0]       crc_err_reg, crc_err_next;
    logic [31:0]       valid_cnt_reg, valid_cnt_next;
    logic              fix_reg, fix_next;

    nmea_result_t      result;
    nmea_result_t      out_reg;
    nmea_result_t      skid_reg;
    logic              out_valid_reg;
    logic              skid_valid_reg;

    logic              s_fire;
    logic              m_fire;
    hex_digit_t        digit;
    logic [31:0]       column;

    assign s_ready = !skid_valid_reg;
    assign s_fire  = s_valid && s_ready;
    assign m_fire  = out_valid_reg && m_ready;
    assign digit   = hex_decode(s_rx_byte);
    assign column  = prefix_column(3'(count_reg - 1'b1));

    always_comb begin
        count_next      = count_reg;
        xor_next        = xor_reg;
        star_next       = star_reg;
        hex_active_next = hex_active_reg;
        hex_value_next  = hex_value_reg;
        nul_next        = nul_reg;
        prefix_next     = prefix_reg;
        crc_err_next    = crc_err_reg;
        valid_cnt_next  = valid_cnt_reg;
        fix_next        = fix_reg;
        result.sentence_done = 1'b0;
        result.checksum_ok   = 1'b0;
        result.sentence_kind = KIND_OTHER;

        if (s_fire) begin
            if (s_rx_byte == CHAR_DOLLAR) begin
                count_next      = CountW'(1);
                xor_next        = 8'h00;
                star_next       = 1'b0;
                hex_active_next = 1'b0;
                hex_value_next  = 8'h00;
                nul_next        = 1'b0;
                prefix_next     = PREFIX_ALL;
            end else if (count_reg != '0 && count_reg < CountLimit) begin
                count_next = count_reg + 1'b1;

                if (count_reg < PrefixEnd) begin
                    for (int k = 0; k < 4; k++) begin
                        if (column[8*k +: 8] != s_rx_byte) begin
                            prefix_next[k] = 1'b0;
                        end
                    end
                end

                if (s_rx_byte == CHAR_NUL) begin
                    nul_next        = 1'b1;
                    hex_active_next = 1'b0;
                end else if (!nul_reg) begin
                    if (hex_active_reg) begin
                        if (!digit.valid) begin
                            hex_active_next = 1'b0;
                        end else begin
                            hex_value_next = {hex_value_reg[3:0], digit.value};
                        end
                    end
                    if (!star_reg) begin
                        if (s_rx_byte == CHAR_STAR) begin
                            star_next       = 1'b1;
                            hex_active_next = 1'b1;
                            hex_value_next  = 8'h00;
                        end else begin
                            xor_next = xor_reg ^ s_rx_byte;
                        end
                    end
                end

                if (s_rx_byte == CHAR_LF || s_rx_byte == CHAR_CR) begin
                    result.sentence_done = 1'b1;
                    count_next           = '0;
                    if (star_next && xor_next == hex_value_next) begin
                        result.checksum_ok = 1'b1;
                        if ((prefix_next & PREFIX_GGA) != 4'h0) begin
                            result.sentence_kind = KIND_GGA;
                            fix_next             = 1'b1;
                            valid_cnt_next       = valid_cnt_reg + 32'd1;
                        end else if ((prefix_next & PREFIX_RMC) != 4'h0) begin
                            result.sentence_kind = KIND_RMC;
                            valid_cnt_next       = valid_cnt_reg + 32'd1;
                        end
                    end else begin
                        crc_err_next = crc_err_reg + 32'd1;
                    end
                end
            end
        end

        result.crc_error_total = crc_err_next;
        result.valid_total     = valid_cnt_next;
        result.fix_valid       = fix_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg      <= '0;
            xor_reg        <= 8'h00;
            star_reg       <= 1'b0;
            hex_active_reg <= 1'b0;
            hex_value_reg  <= 8'h00;
            nul_reg        <= 1'b0;
            prefix_reg     <= PREFIX_ALL;
            crc_err_reg    <= 32'd0;
            valid_cnt_reg  <= 32'd0;
            fix_reg        <= 1'b0;
        end else begin
            count_reg      <= count_next;
            xor_reg        <= xor_next;
            star_reg       <= star_next;
            hex_active_reg <= hex_active_next;
            hex_value_reg  <= hex_value_next;
            nul_reg        <= nul_next;
            prefix_reg     <= prefix_next;
            crc_err_reg    <= crc_err_next;
            valid_cnt_reg  <= valid_cnt_next;
            fix_reg        <= fix_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (!out_valid_reg || m_fire) begin
            if (skid_valid_reg) begin
                out_reg        <= skid_reg;
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else if (s_fire) begin
                out_reg       <= result;
                out_valid_reg <= 1'b1;
            end else begin
                out_valid_reg <= 1'b0;
            end
        end else if (s_fire) begin
            skid_reg       <= result;
            skid_valid_reg <= 1'b1;
        end
    end

    assign m_valid           = out_valid_reg;
    assign m_sentence_done   = out_reg.sentence_done;
    assign m_checksum_ok     = out_reg.checksum_ok;
    assign m_sentence_kind   = out_reg.sentence_kind;
    assign m_crc_error_total = out_reg.crc_error_total;
    assign m_valid_total     = out_reg.valid_total;
    assign m_fix_valid       = out_reg.fix_valid;

    `NSC_ASSERT_SAME(a_skid_behind_out, skid_valid_reg, out_valid_reg)
    `NSC_ASSERT_NEXT(a_dollar_opens, s_fire && s_rx_byte == CHAR_DOLLAR, count_reg == CountW'(1))
    `NSC_ASSERT_NEXT(a_fix_sticky, fix_reg, fix_reg)
    `NSC_ASSERT_SAME(a_count_bounded, 1'b1, count_reg <= CountLimit)

endmodule

// ----- dv/nmea_sb_pkg.sv -----
// ---------------------------------------------------------------------------
// NMEA sentence checker scoreboard
// Tracks sentence state byte by byte, predicts one result per accepted byte
// and compares each returned result with the oldest prediction.
// ---------------------------------------------------------------------------
package nmea_sb_pkg;
    import nmea_sc_pkg::*;

    localparam logic [7:0] ASCII_0  = 8'h30;
    localparam logic [7:0] ASCII_9  = 8'h39;
    localparam logic [7:0] ASCII_UA = 8'h41;
    localparam logic [7:0] ASCII_UF = 8'h46;
    localparam logic [7:0] ASCII_LA = 8'h61;
    localparam logic [7:0] ASCII_LF = 8'h66;

    class nmea_scoreboard;
        int unsigned  cap;
        int unsigned  fill;
        logic [7:0]   xor_sum;
        logic [7:0]   hex_acc;
        bit           star;
        bit           hex_on;
        bit           nul_hit;
        logic [3:0]   heads_alive;
        logic [31:0]  bad_sums;
        logic [31:0]  good_sentences;
        bit           fix;
        nmea_result_t verdict_q[$];
        int unsigned  mismatches;

        function new(int unsigned buffer_bytes);
            cap            = buffer_bytes;
            fill           = 0;
            xor_sum        = '0;
            hex_acc        = '0;
            star           = 1'b0;
            hex_on         = 1'b0;
            nul_hit        = 1'b0;
            heads_alive    = PREFIX_ALL;
            bad_sums       = '0;
            good_sentences = '0;
            fix            = 1'b0;
            mismatches     = 0;
        endfunction

        function logic [7:0] head_char(int unsigned k, int unsigned pos);
            string name;
            case (k)
                0: name = "GPGGA";
                1: name = "GNGGA";
                2: name = "GPRMC";
                default: name = "GNRMC";
            endcase
            return name[pos];
        endfunction

        function bit hex_value_of(logic [7:0] b, output logic [3:0] v);
            v = '0;
            if (b >= ASCII_0 && b <= ASCII_9) begin
                v = b[3:0];
                return 1'b1;
            end
            if ((b >= ASCII_UA && b <= ASCII_UF) || (b >= ASCII_LA && b <= ASCII_LF)) begin
                v = b[3:0] + 4'd9;
                return 1'b1;
            end
            return 1'b0;
        endfunction

        function void note_byte(logic [7:0] b);
            nmea_result_t r;
            int unsigned  pos;
            logic [3:0]   d;
            r = '0;
            r.sentence_kind = KIND_OTHER;
            if (b == CHAR_DOLLAR) begin
                fill        = 1;
                xor_sum     = '0;
                star        = 1'b0;
                hex_on      = 1'b0;
                hex_acc     = '0;
                nul_hit     = 1'b0;
                heads_alive = PREFIX_ALL;
            end else if (fill > 0 && fill < cap - 1) begin
                pos = fill;
                fill++;
                if (pos < PREFIX_LEN) begin
                    for (int k = 0; k < 4; k++) begin
                        if (head_char(k, pos - 1) != b) begin
                            heads_alive[k] = 1'b0;
                        end
                    end
                end
                if (b == CHAR_NUL) begin
                    nul_hit = 1'b1;
                    hex_on  = 1'b0;
                end else if (!nul_hit) begin
                    if (hex_on) begin
                        if (hex_value_of(b, d)) begin
                            hex_acc = {hex_acc[3:0], d};
                        end else begin
                            hex_on = 1'b0;
                        end
                    end
                    if (!star) begin
                        if (b == CHAR_STAR) begin
                            star    = 1'b1;
                            hex_on  = 1'b1;
                            hex_acc = '0;
                        end else begin
                            xor_sum ^= b;
                        end
                    end
                end
                if (b == CHAR_LF || b == CHAR_CR) begin
                    r.sentence_done = 1'b1;
                    if (star && xor_sum == hex_acc) begin
                        r.checksum_ok = 1'b1;
                        if ((heads_alive & PREFIX_GGA) != '0) begin
                            r.sentence_kind = KIND_GGA;
                            fix = 1'b1;
                            good_sentences++;
                        end else if ((heads_alive & PREFIX_RMC) != '0) begin
                            r.sentence_kind = KIND_RMC;
                            good_sentences++;
                        end
                    end else begin
                        bad_sums++;
                    end
                    fill = 0;
                end
            end
            r.crc_error_total = bad_sums;
            r.valid_total     = good_sentences;
            r.fix_valid       = fix;
            verdict_q.push_back(r);
        endfunction

        function void cmp_field(string what, logic [31:0] want, logic [31:0] got);
            if (want !== got) begin
                $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
                mismatches++;
            end
        endfunction

        function void check_result(nmea_result_t got);
            nmea_result_t want;
            if (verdict_q.size() == 0) begin
                $display("%0t: result with no request outstanding, actual %0h", $time, got);
                mismatches++;
                return;
            end
            want = verdict_q.pop_front();
            cmp_field("sentence_done", 32'(want.sentence_done), 32'(got.sentence_done));
            cmp_field("checksum_ok", 32'(want.checksum_ok), 32'(got.checksum_ok));
            cmp_field("sentence_kind", 32'(want.sentence_kind), 32'(got.sentence_kind));
            cmp_field("crc_error_total", want.crc_error_total, got.crc_error_total);
            cmp_field("valid_total", want.valid_total, got.valid_total);
            cmp_field("fix_valid", 32'(want.fix_valid), 32'(got.fix_valid));
        endfunction

        function int unsigned pending();
            return verdict_q.size();
        endfunction
    endclass

endpackage

// ----- dv/tb_top.sv -----
// ---------------------------------------------------------------------------
// NMEA sentence checker testbench
// Streams framed sentences, broken sentences and line noise into the checker
// with random gaps and back-pressure, and checks every result.
// ---------------------------------------------------------------------------
module tb_top;
    import nmea_sc_pkg::*;
    import nmea_sb_pkg::*;

    localparam int unsigned SENTENCE_CAP = BUFFER_BYTES_DEFAULT;
    localparam int unsigned BYTE_TARGET  = 700;
    localparam int unsigned QUIET_TAIL   = 100;

    typedef enum logic [2:0] {
        HEX_UPPER,
        HEX_LOWER,
        HEX_THREE,
        HEX_ONE,
        HEX_NONE,
        HEX_WRONG
    } hex_style_e;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_valid   = 1'b0;
    logic        s_ready;
    logic [7:0]  s_rx_byte = 8'h00;
    logic        m_valid;
    logic        m_ready   = 1'b0;
    logic        m_sentence_done;
    logic        m_checksum_ok;
    logic [1:0]  m_sentence_kind;
    logic [31:0] m_crc_error_total;
    logic [31:0] m_valid_total;
    logic        m_fix_valid;

    nmea_scoreboard sb;
    logic [7:0]     line_q[$];
    int unsigned    sent_total   = 0;
    int unsigned    stall_left   = 0;
    bit             tx_gaps_on   = 1'b0;
    bit             rx_stalls_on = 1'b0;

    always #1 aclk = ~aclk;

    nmea_sentence_checker #(
        .BUFFER_BYTES(SENTENCE_CAP)
    ) dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_rx_byte         (s_rx_byte),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_sentence_done   (m_sentence_done),
        .m_checksum_ok     (m_checksum_ok),
        .m_sentence_kind   (m_sentence_kind),
        .m_crc_error_total (m_crc_error_total),
        .m_valid_total     (m_valid_total),
        .m_fix_valid       (m_fix_valid)
    );

    task automatic push_byte(input logic [7:0] value);
        if (tx_gaps_on && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_rx_byte <= value;
        do @(posedge aclk); while (!s_ready);
        sb.note_byte(value);
    endtask

    task automatic add_text(input string s);
        for (int i = 0; i < s.len(); i++) begin
            line_q.push_back(s[i]);
        end
    endtask

    task automatic add_end(input bit cr, input bit lf);
        if (cr) begin
            line_q.push_back(CHAR_CR);
        end
        if (lf) begin
            line_q.push_back(CHAR_LF);
        end
    endtask

    function automatic logic [7:0] line_checksum();
        int         start;
        logic [7:0] acc;
        start = 0;
        acc   = '0;
        for (int i = 0; i < line_q.size(); i++) begin
            if (line_q[i] == CHAR_DOLLAR) begin
                start = i + 1;
            end
        end
        for (int i = start; i < line_q.size(); i++) begin
            if (line_q[i] == CHAR_STAR || line_q[i] == CHAR_NUL) begin
                break;
            end
            acc ^= line_q[i];
        end
        return acc;
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] v, input bit lower);
        if (v < 4'd10) begin
            return ASCII_0 + 8'(v);
        end
        return (lower ? ASCII_LA : ASCII_UA) + 8'(v) - 8'd10;
    endfunction

    function automatic logic [7:0] body_char();
        logic [7:0] c;
        do begin
            c = 8'($urandom_range(32, 126));
        end while (c == CHAR_DOLLAR || c == CHAR_STAR);
        return c;
    endfunction

    task automatic add_check(input hex_style_e style);
        logic [7:0] sum;
        sum = line_checksum();
        line_q.push_back(CHAR_STAR);
        case (style)
            HEX_LOWER: begin
                line_q.push_back(hex_char(sum[7:4], 1'b1));
                line_q.push_back(hex_char(sum[3:0], 1'b1));
            end
            HEX_THREE: begin
                line_q.push_back(hex_char(4'($urandom_range(0, 15)), 1'b0));
                line_q.push_back(hex_char(sum[7:4], 1'b0));
                line_q.push_back(hex_char(sum[3:0], 1'b1));
            end
            HEX_ONE: begin
                line_q.push_back(hex_char(sum[3:0], 1'b0));
            end
            HEX_NONE: begin
            end
            HEX_WRONG: begin
                sum ^= 8'($urandom_range(1, 255));
                line_q.push_back(hex_char(sum[7:4], 1'b0));
                line_q.push_back(hex_char(sum[3:0], 1'b0));
            end
            default: begin
                line_q.push_back(hex_char(sum[7:4], 1'b0));
                line_q.push_back(hex_char(sum[3:0], 1'b0));
            end
        endcase
    endtask

    task automatic flush_line();
        foreach (line_q[i]) begin
            push_byte(line_q[i]);
        end
        sent_total += line_q.size();
        line_q.delete();
    endtask

    task automatic spray_noise();
        int unsigned count;
        count = $urandom_range(1, 6);
        repeat (count) push_byte(8'($urandom_range(0, 255)));
    endtask

    task automatic run_directed();
        line_q.push_back(CHAR_DOLLAR);
        add_text("GPGGA,");
        line_q.push_back(8'hFF);
        line_q.push_back(8'h80);
        add_check(HEX_UPPER);
        add_end(1'b1, 1'b1);
        line_q.push_back(CHAR_DOLLAR);
        add_text("GNGGA");
        add_check(HEX_THREE);
        add_end(1'b1, 1'b0);
        line_q.push_back(CHAR_DOLLAR);
        add_text("GPRMC");
        add_check(HEX_LOWER);
        add_end(1'b0, 1'b1);
        line_q.push_back(CHAR_DOLLAR);
        add_text("GNRMC");
        add_check(HEX_UPPER);
        add_end(1'b1, 1'b0);
        line_q.push_back(CHAR_DOLLAR);
        add_text("GPGSV");
        add_check(HEX_UPPER);
        add_end(1'b1, 1'b0);
        line_q.push_back(CHAR_DOLLAR);
        add_text("GPR");
        add_check(HEX_WRONG);
        add_end(1'b1, 1'b0);
        add_text("$GPGGA");
        add_end(1'b1, 1'b0);
        add_text("$GP");
        line_q.push_back(CHAR_NUL);
        add_text("*17");
        add_end(1'b1, 1'b0);
        add_text("$X*");
        line_q.push_back(CHAR_NUL);
        add_text("58");
        add_end(1'b0, 1'b1);
        add_text("$GPR");
        line_q.push_back(CHAR_DOLLAR);
        add_text("GNGGA");
        add_check(HEX_UPPER);
        add_end(1'b1, 1'b0);
        line_q.push_back(8'hFF);
        line_q.push_back(CHAR_STAR);
        line_q.push_back(CHAR_CR);
        line_q.push_back(CHAR_DOLLAR);
        add_check(HEX_NONE);
        add_end(1'b1, 1'b0);
        line_q.push_back(CHAR_DOLLAR);
        add_text("GP");
        add_check(HEX_ONE);
        add_end(1'b1, 1'b0);
        flush_line();
    endtask

    task automatic random_sentence(input bit long_body);
        int unsigned pick;
        int unsigned body_len;
        int unsigned nul_at;
        hex_style_e  style;
        line_q.push_back(CHAR_DOLLAR);
        pick = $urandom_range(0, 9);
        case (pick)
            0, 1: add_text("GPGGA");
            2: add_text("GNGGA");
            3, 4: add_text("GPRMC");
            5: add_text("GNRMC");
            6: add_text("GPGSV");
            7: begin
                add_text($urandom_range(0, 1) ? "GNGGA" : "GPRMC");
                line_q[line_q.size() - 1 - $urandom_range(0, 4)] = body_char();
            end
            8: add_text("GP");
            default: begin
            end
        endcase
        body_len = long_body ? $urandom_range(118, 135) : $urandom_range(0, 16);
        nul_at   = ($urandom_range(0, 11) == 0) ? $urandom_range(0, body_len) : body_len + 1;
        for (int unsigned i = 0; i <= body_len; i++) begin
            if (i == nul_at) begin
                line_q.push_back(CHAR_NUL);
            end
            if (i < body_len) begin
                line_q.push_back(body_char());
            end
        end
        if ($urandom_range(0, 14) != 0) begin
            pick = $urandom_range(0, 9);
            case (pick)
                0, 1, 2, 3: style = HEX_UPPER;
                4, 5: style = HEX_LOWER;
                6: style = HEX_THREE;
                7: style = HEX_ONE;
                8: style = HEX_NONE;
                default: style = HEX_WRONG;
            endcase
            add_check(style);
            if ($urandom_range(0, 9) == 0) begin
                add_text($urandom_range(0, 1) ? ",7F" : "G");
            end
        end
        pick = $urandom_range(0, 11);
        case (pick)
            0: begin
            end
            1, 2: add_end(1'b1, 1'b0);
            3, 4: add_end(1'b0, 1'b1);
            default: add_end(1'b1, 1'b1);
        endcase
        flush_line();
    endtask

    always @(posedge aclk) begin
        nmea_result_t seen;
        if (aresetn && m_valid && m_ready) begin
            seen.sentence_done   = m_sentence_done;
            seen.checksum_ok     = m_checksum_ok;
            seen.sentence_kind   = m_sentence_kind;
            seen.crc_error_total = m_crc_error_total;
            seen.valid_total     = m_valid_total;
            seen.fix_valid       = m_fix_valid;
            sb.check_result(seen);
        end
        if (stall_left != 0) begin
            stall_left--;
            m_ready <= 1'b0;
        end else if (rx_stalls_on && $urandom_range(0, 4) == 0) begin
            stall_left = $urandom_range(0, 3);
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    initial begin
        int unsigned n;
        sb = new(SENTENCE_CAP);
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        tx_gaps_on   = 1'b1;
        rx_stalls_on = 1'b1;
        run_directed();
        n = 0;
        while (sent_total < BYTE_TARGET) begin
            tx_gaps_on   = (sent_total < BYTE_TARGET - QUIET_TAIL) && ($urandom_range(0, 3) != 0);
            rx_stalls_on = (sent_total < BYTE_TARGET - QUIET_TAIL) && ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 4) == 0) begin
                spray_noise();
            end
            random_sentence(n == 2 || n == 7 || $urandom_range(0, 24) == 0);
            n++;
        end
        tx_gaps_on   = 1'b0;
        rx_stalls_on = 1'b0;
        s_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
        if (sb.mismatches == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    initial begin
        #400000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+design
design/nmea_sc_pkg.sv
design/nmea_sentence_checker.sv
dv/nmea_sb_pkg.sv
dv/tb_top.sv
